// ===== design/stt_pkg.sv =====
package stt_pkg;

    localparam int unsigned DIM_W   = 9;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned COUNT_W = 9;
    localparam logic [DIM_W-1:0] DEFAULT_DIM = DIM_W'(4);

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } reg_index_t;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } state_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    found;
        status_t                 status;
        logic [COUNT_W-1:0]      entry_count;
    } resp_t;

    // One stored triplet
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
    } triplet_t;

    // Commit strobes broadcast to every cell
    typedef struct packed {
        logic insert;
        logic write;
    } cell_ctl_t;

endpackage

// ===== design/stt_cell.sv =====
module stt_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 9
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cmp_en,
    input  logic [stt_pkg::IDX_W-1:0]                key_row,
    input  logic [stt_pkg::IDX_W-1:0]                key_col,
    input  logic [CNT_W-1:0]                         count,
    input  stt_pkg::cell_ctl_t                       ctl,
    input  stt_pkg::triplet_t                        new_entry,
    input  stt_pkg::triplet_t                        prev_data,
    input  logic                                     prev_ge,
    output stt_pkg::triplet_t                        data,
    output logic                                     ge,
    output logic                                     eq,
    output logic signed [stt_pkg::VAL_W-1:0]         hit_val
);
    import stt_pkg::*;

    triplet_t                data_reg;
    triplet_t                data_next;
    logic                    ge_reg;
    logic                    eq_reg;
    logic signed [VAL_W-1:0] hit_val_reg;
    logic                    in_use;
    logic                    less;
    logic                    match;

    assign in_use = CNT_W'(IDX) < count;
    assign less   = (data_reg.row < key_row) ||
                    ((data_reg.row == key_row) && (data_reg.col < key_col));
    assign match  = in_use && (data_reg.row == key_row) && (data_reg.col == key_col);

    // Sorted order makes the cells at or past the slot a suffix of the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (cmp_en)
        begin
            ge_reg <= !(in_use && less);
            eq_reg <= match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            hit_val_reg <= match ? data_reg.val : '0;
        end
    end

    always_comb
    begin
        data_next = data_reg;
        if (ctl.insert && ge_reg)
        begin
            // take the neighbor's triplet, or the new one at the slot itself
            data_next = prev_ge ? prev_data : new_entry;
        end
        else if (ctl.write && eq_reg)
        begin
            data_next.val = new_entry.val;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign ge      = ge_reg;
    assign eq      = eq_reg;
    assign hit_val = hit_val_reg;

endmodule

// ===== design/sparse_triplet_table.sv =====
// Flow: a request is taken while idle and all cells compare it in parallel; in the
// update state, once the response register is free, the commit (write or shift) is
// made and the response is registered. No new request is taken until the last one
// has committed; the next request is taken while the response waits to be taken.
// Reset: entry count cleared, size registers set to 4x4; cell contents are not
// cleared, cells at or beyond the entry count are never read.
module sparse_triplet_table #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  stt_pkg::req_t       request,
    output logic                resp_valid,
    input  logic                resp_ready,
    output stt_pkg::resp_t      response,
    input  logic                write_enable,
    input  stt_pkg::reg_index_t reg_index,
    input  logic [stt_pkg::DIM_W-1:0] write_data
);
    import stt_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    state_t                  state_reg;
    state_t                  state_next;
    logic [DIM_W-1:0]        rows_reg;
    logic [DIM_W-1:0]        cols_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    req_t                    req_reg;
    logic                    bad_pos_reg;
    resp_t                   resp_reg;
    resp_t                   resp_next;
    logic                    resp_valid_reg;
    logic                    resp_valid_next;
    logic                    accept;
    logic                    commit;
    cell_ctl_t               ctl;
    triplet_t                new_entry;
    triplet_t                data_vec [CAPACITY];
    logic [CAPACITY-1:0]     ge_vec;
    logic [CAPACITY-1:0]     eq_vec;
    logic signed [VAL_W-1:0] hit_vals [CAPACITY];
    logic signed [VAL_W-1:0] hit_or;
    logic                    hit;
    logic                    full;

    assign req_ready  = (state_reg == S_IDLE);
    assign accept     = req_valid && req_ready;
    assign commit     = (state_reg == S_UPDATE) && (!resp_valid_reg || resp_ready);
    assign resp_valid = resp_valid_reg;
    assign response   = resp_reg;
    assign full       = (count_reg == CNT_W'(CAPACITY));

    assign new_entry.row = req_reg.row_index;
    assign new_entry.col = req_reg.col_index;
    assign new_entry.val = req_reg.write_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DEFAULT_DIM;
            cols_reg <= DEFAULT_DIM;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                REG_ROWS: rows_reg <= write_data;
                REG_COLS: cols_reg <= write_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= request;
            bad_pos_reg <= ({1'b0, request.row_index} >= rows_reg) ||
                           ({1'b0, request.col_index} >= cols_reg);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            triplet_t prev_data;
            logic     prev_ge;
            if (gi == 0)
            begin : g_head
                assign prev_data = new_entry;
                assign prev_ge   = 1'b0;
            end
            else
            begin : g_link
                assign prev_data = data_vec[gi-1];
                assign prev_ge   = ge_vec[gi-1];
            end
            stt_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmp_en    (accept),
                .key_row   (request.row_index),
                .key_col   (request.col_index),
                .count     (count_reg),
                .ctl       (ctl),
                .new_entry (new_entry),
                .prev_data (prev_data),
                .prev_ge   (prev_ge),
                .data      (data_vec[gi]),
                .ge        (ge_vec[gi]),
                .eq        (eq_vec[gi]),
                .hit_val   (hit_vals[gi])
            );
        end
    endgenerate

    // At most one cell matches, so an OR picks its value
    always_comb
    begin
        hit_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_or = hit_or | hit_vals[i];
        end
    end

    assign hit = |eq_vec;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        resp_next       = resp_reg;
        resp_valid_next = resp_valid_reg;
        ctl             = '0;

        if (resp_valid_reg && resp_ready)
        begin
            resp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (commit)
                begin
                    resp_next.read_value = '0;
                    resp_next.found      = 1'b0;
                    resp_next.status     = ST_OK;
                    case (req_reg.cmd) inside
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_GET, CMD_SET:
                        begin
                            if (bad_pos_reg)
                            begin
                                resp_next.status = ST_RANGE;
                            end
                            else
                            begin
                                resp_next.found = hit;
                                if (req_reg.cmd == CMD_GET)
                                begin
                                    resp_next.read_value = hit_or;
                                end
                                else if (hit)
                                begin
                                    ctl.write = 1'b1;
                                end
                                else if (full)
                                begin
                                    resp_next.status = ST_FULL;
                                end
                                else
                                begin
                                    ctl.insert = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    resp_next.entry_count = COUNT_W'(count_next);
                    resp_valid_next       = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        resp_reg <= resp_next;
    end

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPDATE |-> $onehot0(eq_vec))
        else $error("more than one cell matches the key");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the entry count");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid_reg && resp_reg.found |-> resp_reg.status == ST_OK)
        else $error("found set on a rejected request");

    a_no_hit_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |-> !hit && !full)
        else $error("insert with a hit or a full table");

endmodule

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_PER_SETTING = 16;
    localparam int unsigned HOLD_OFF_CYCLES = 80;

    typedef struct {
        req_t  rq;
        bit    typed;
        resp_t rs;
    } vector_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    req_t           request = '0;
    logic           resp_valid;
    logic           resp_ready = 1'b0;
    resp_t          response;
    logic           write_enable = 1'b0;
    reg_index_t     reg_index = REG_ROWS;
    logic [DIM_W-1:0] write_data = '0;

    // Shadow copy of the table and of the size registers
    logic [IDX_W-1:0]        tab_row [TABLE_DEPTH];
    logic [IDX_W-1:0]        tab_col [TABLE_DEPTH];
    logic signed [VAL_W-1:0] tab_val [TABLE_DEPTH];
    int unsigned             tab_count = 0;
    logic [DIM_W-1:0]        rows_cfg = DEFAULT_DIM;
    logic [DIM_W-1:0]        cols_cfg = DEFAULT_DIM;

    resp_t       pending_results[$];
    logic [15:0] hot_spots[$];

    int unsigned sender_idle = 8;
    int unsigned receiver_idle = 88;
    bit          stall_request = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned hits_seen = 0;
    int unsigned range_seen = 0;
    int unsigned full_seen = 0;

    int unsigned phase_rows[6] = '{256, 1, 0, 16, 5, 511};
    int unsigned phase_cols[6] = '{256, 1, 5, 16, 0, 3};

    sparse_triplet_table #(
        .CAPACITY(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .request(request),
        .resp_valid(resp_valid),
        .resp_ready(resp_ready),
        .response(response),
        .write_enable(write_enable),
        .reg_index(reg_index),
        .write_data(write_data)
    );

    always #5 clk = ~clk;

    function automatic resp_t table_step(req_t rq);
        resp_t       rs;
        int unsigned k;
        int unsigned m;
        bit          hit;
        rs = '0;
        rs.status = ST_OK;
        case (rq.cmd) inside
            CMD_CLEAR: tab_count = 0;
            CMD_GET, CMD_SET:
            begin
                if (rq.row_index >= rows_cfg || rq.col_index >= cols_cfg)
                begin
                    rs.status = ST_RANGE;
                end
                else
                begin
                    k = 0;
                    while (k < tab_count && (tab_row[k] < rq.row_index ||
                           (tab_row[k] == rq.row_index && tab_col[k] < rq.col_index)))
                        k++;
                    hit = k < tab_count && tab_row[k] == rq.row_index &&
                          tab_col[k] == rq.col_index;
                    rs.found = hit;
                    if (rq.cmd == CMD_GET)
                    begin
                        if (hit)
                            rs.read_value = tab_val[k];
                    end
                    else if (hit)
                    begin
                        tab_val[k] = rq.write_value;
                    end
                    else if (tab_count >= TABLE_DEPTH)
                    begin
                        rs.status = ST_FULL;
                    end
                    else
                    begin
                        // shift later triplets up to open the sorted slot
                        for (m = tab_count; m > k; m--)
                        begin
                            tab_row[m] = tab_row[m-1];
                            tab_col[m] = tab_col[m-1];
                            tab_val[m] = tab_val[m-1];
                        end
                        tab_row[k] = rq.row_index;
                        tab_col[k] = rq.col_index;
                        tab_val[k] = rq.write_value;
                        tab_count++;
                    end
                end
            end
            CMD_NONE: ;
            default: ;
        endcase
        rs.entry_count = COUNT_W'(tab_count);
        return rs;
    endfunction

    function automatic req_t make_request(cmd_t c, int r, int col, logic [31:0] v);
        req_t rq;
        rq.cmd = c;
        rq.row_index = IDX_W'(r);
        rq.col_index = IDX_W'(col);
        rq.write_value = v;
        return rq;
    endfunction

    function automatic vector_t plain(cmd_t c, int r, int col, logic [31:0] v);
        vector_t vec;
        vec.rq = make_request(c, r, col, v);
        vec.typed = 1'b0;
        vec.rs = '0;
        return vec;
    endfunction

    function automatic vector_t known(cmd_t c, int r, int col, logic [31:0] v,
                                      logic [31:0] rd, bit fnd, status_t st, int n);
        vector_t vec;
        vec.rq = make_request(c, r, col, v);
        vec.typed = 1'b1;
        vec.rs.read_value = rd;
        vec.rs.found = fnd;
        vec.rs.status = st;
        vec.rs.entry_count = COUNT_W'(n);
        return vec;
    endfunction

    function automatic req_t random_request();
        int unsigned pick;
        int          row_top;
        int          col_top;
        logic [15:0] spot;
        req_t        rq;
        pick = $urandom_range(99);
        row_top = (rows_cfg == 0) ? 0 : ((rows_cfg > 256) ? 255 : int'(rows_cfg) - 1);
        col_top = (cols_cfg == 0) ? 0 : ((cols_cfg > 256) ? 255 : int'(cols_cfg) - 1);
        rq = make_request(CMD_GET, $urandom_range(row_top), $urandom_range(col_top),
                          $urandom());
        if (pick < 5)
        begin
            rq.cmd = CMD_CLEAR;
        end
        else if (pick < 8)
        begin
            rq.cmd = CMD_NONE;
        end
        else if (pick < 15)
        begin
            // noise: any position, mostly out of range
            rq.cmd = ($urandom_range(1) == 0) ? CMD_GET : CMD_SET;
            rq.row_index = IDX_W'($urandom_range(255));
            rq.col_index = IDX_W'($urandom_range(255));
        end
        else if (pick < 55)
        begin
            rq.cmd = CMD_SET;
            if (hot_spots.size() != 0 && $urandom_range(3) == 0)
                {rq.row_index, rq.col_index} = hot_spots[$urandom_range(hot_spots.size()-1)];
            hot_spots.push_back({rq.row_index, rq.col_index});
            if (hot_spots.size() > 32)
                spot = hot_spots.pop_front();
        end
        else if (hot_spots.size() != 0 && $urandom_range(9) < 7)
        begin
            {rq.row_index, rq.col_index} = hot_spots[$urandom_range(hot_spots.size()-1)];
        end
        return rq;
    endfunction

    task automatic send(input req_t item, input bit typed, input resp_t typed_rs);
        resp_t predicted;
        while ($urandom_range(99) < sender_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        request <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = table_step(item);
        pending_results.push_back(typed ? typed_rs : predicted);
        requests_sent++;
    endtask

    // Drop valid and wait for every outstanding response
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic config_dims(input int unsigned rows, input int unsigned cols);
        write_enable <= 1'b1;
        reg_index <= REG_ROWS;
        write_data <= DIM_W'(rows);
        @(posedge clk);
        reg_index <= REG_COLS;
        write_data <= DIM_W'(cols);
        @(posedge clk);
        write_enable <= 1'b0;
        rows_cfg = DIM_W'(rows);
        cols_cfg = DIM_W'(cols);
        hot_spots.delete();
        @(posedge clk);
    endtask

    task automatic report(input string what, input resp_t exp, input resp_t got);
        if (mismatches < 10)
        begin
            $display("mismatch (%s) at cycle %0d", what, cycle_count);
            $display("  expected rd=%0d fnd=%0d st=%0d cnt=%0d",
                     exp.read_value, exp.found, exp.status, exp.entry_count);
            $display("  got      rd=%0d fnd=%0d st=%0d cnt=%0d",
                     got.read_value, got.found, got.status, got.entry_count);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        resp_t exp;
        resp_t got;
        if (resp_valid && resp_ready)
        begin
            got = response;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report("no request pending", '0, got);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.read_value != exp.read_value || got.found != exp.found ||
                    got.status != exp.status || got.entry_count != exp.entry_count)
                    report("field", exp, got);
                if (exp.found)
                    hits_seen++;
                if (exp.status == ST_RANGE)
                    range_seen++;
                if (exp.status == ST_FULL)
                    full_seen++;
            end
        end
        // hold off for a long stretch when asked, else stall at random
        if (stall_left > 0)
        begin
            resp_ready <= 1'b0;
            stall_left--;
        end
        else if (stall_request)
        begin
            stall_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
            resp_ready <= 1'b0;
        end
        else
        begin
            resp_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    initial
    begin
        vector_t     directed_rows[$];
        logic [15:0] grid[TABLE_DEPTH];
        logic [15:0] swap;
        int unsigned i;
        int unsigned j;
        int unsigned phase;
        req_t        rq;

        directed_rows = '{
            known(CMD_GET,     0,   0, 32'h0,        32'h0,        0, ST_OK,    0),
            known(CMD_SET,     0,   0, 32'h7FFFFFFF, 32'h0,        0, ST_OK,    1),
            known(CMD_SET,     3,   3, 32'h80000000, 32'h0,        0, ST_OK,    2),
            known(CMD_GET,     3,   3, 32'h0,        32'h80000000, 1, ST_OK,    2),
            known(CMD_GET,     0,   0, 32'hFFFFFFFF, 32'h7FFFFFFF, 1, ST_OK,    2),
            known(CMD_SET,     4,   0, 32'h1,        32'h0,        0, ST_RANGE, 2),
            known(CMD_SET,     0,   4, 32'h1,        32'h0,        0, ST_RANGE, 2),
            known(CMD_GET,   255, 255, 32'h0,        32'h0,        0, ST_RANGE, 2),
            known(CMD_SET,     1,   2, 32'hFFFFFFFF, 32'h0,        0, ST_OK,    3),
            known(CMD_SET,     1,   0, 32'h5,        32'h0,        0, ST_OK,    4),
            known(CMD_SET,     1,   2, 32'h0,        32'h0,        1, ST_OK,    4),
            known(CMD_GET,     1,   2, 32'h0,        32'h0,        1, ST_OK,    4),
            known(CMD_GET,     1,   1, 32'h0,        32'h0,        0, ST_OK,    4),
            plain(CMD_SET,     0,   3, 32'h12345678),
            plain(CMD_SET,     2,   1, 32'hDEADBEEF),
            known(CMD_GET,     1,   0, 32'h0,        32'h5,        1, ST_OK,    6),
            known(CMD_NONE,  255, 255, 32'hFFFFFFFF, 32'h0,        0, ST_OK,    6),
            plain(CMD_GET,     2,   1, 32'h0),
            plain(CMD_GET,     3,   3, 32'h0),
            known(CMD_CLEAR, 255, 255, 32'hFFFFFFFF, 32'h0,        0, ST_OK,    0),
            known(CMD_GET,     0,   0, 32'h0,        32'h0,        0, ST_OK,    0),
            plain(CMD_SET,     2,   2, 32'h55555555),
            plain(CMD_SET,     2,   2, 32'hAAAAAAAA),
            plain(CMD_GET,     2,   2, 32'h0)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs on the reset size of 4x4
        foreach (directed_rows[n])
            send(directed_rows[n].rq, directed_rows[n].typed, directed_rows[n].rs);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0: begin sender_idle = 8;  receiver_idle = 88; end
                1: begin sender_idle = 88; receiver_idle = 8;  end
                default: begin sender_idle = 0; receiver_idle = 0; end
            endcase
            config_dims(phase_rows[phase], phase_cols[phase]);
            repeat (RANDOM_PER_SETTING)
                send(random_request(), 1'b0, '0);
            drain();
        end

        // fill a 16x16 block in random order, then push past capacity
        config_dims(17, 16);
        for (i = 0; i < TABLE_DEPTH; i++)
            grid[i] = 16'(i);
        for (i = TABLE_DEPTH - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            swap = grid[i];
            grid[i] = grid[j];
            grid[j] = swap;
        end
        send(make_request(CMD_CLEAR, 0, 0, 32'h0), 1'b0, '0);
        stall_request = 1'b1;
        for (i = 0; i < TABLE_DEPTH; i++)
            send(make_request(CMD_SET, grid[i][7:4], grid[i][3:0], $urandom()), 1'b0, '0);
        repeat (24)
        begin
            rq = make_request(($urandom_range(1) == 0) ? CMD_GET : CMD_SET,
                              $urandom_range(17), $urandom_range(16), $urandom());
            send(rq, 1'b0, '0);
        end
        send(make_request(CMD_CLEAR, 0, 0, 32'h0), 1'b0, '0);
        drain();

        repeat (10) @(posedge clk);
        $display("Covered %0d requests: directed rows, 6 sizes incl. zero and max, full fill.",
                 requests_sent);
        $display("Results: %0d checked, %0d hits, %0d range, %0d full, %0d mismatches.",
                 results_seen, hits_seen, range_seen, full_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
